// ===== src/frp_pkg.sv =====
package frp_pkg;

    // Width of a reduced input component magnitude and of its signed form
    localparam int RED_BITS = 16;
    localparam int D_W      = RED_BITS + 1;
    // d x s partial products and the exact third axis
    localparam int P1_W     = 2 * D_W - 1;
    localparam int C_W      = P1_W + 1;
    // c x d partial products and the exact side axis
    localparam int P2_W     = C_W + D_W - 1;
    localparam int Q_W      = P2_W + 1;
    localparam int MAG_W    = Q_W - 1;
    localparam int LEN_W    = 6;

    // Normalizer internals
    localparam int UNIT_BITS  = 30;
    localparam int M_W        = UNIT_BITS + 1;
    localparam int SQ_W       = 2 * M_W;
    localparam int N_W        = 64;
    localparam int ROOT_W     = N_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int NUM_W      = M_W + UNIT_BITS + 1;
    localparam int QT_W       = UNIT_BITS + 1;
    localparam int DREM_W     = ROOT_W;
    localparam int U_W        = UNIT_BITS + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QT_W;
    localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    // Matrix product and result
    localparam int PROD_W    = 2 * U_W - 2;
    localparam int ACC_W     = 64;
    localparam int OUT_W     = 16;
    localparam int N_ENTRIES = 9;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [2:0][Q_W-1:0] frp_vec_t;
    typedef logic [2:0][U_W-1:0] frp_unit_t;

    // One classified frame pair: exact axes of both frames and the flag
    typedef struct packed {
        logic [1:0][2:0][D_W-1:0] dir;
        logic [1:0][2:0][Q_W-1:0] side;
        logic [1:0][2:0][C_W-1:0] third;
        logic                     deg;
    } frp_entry_t;

endpackage

// ===== src/frp_norm.sv =====
module frp_norm
    import frp_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  frp_vec_t  vec,
    output frp_unit_t unit
);

    function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] x);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (x[b])
            begin
                len = LEN_W'(b + 1);
            end
        end
        return len;
    endfunction

    function automatic logic [M_W-1:0] scale(input logic [MAG_W-1:0] mag,
                                             input logic [LEN_W-1:0] len);
        logic [M_W-1:0] s;
        if (len > LEN_W'(M_W))
        begin
            s = M_W'(mag >> (len - LEN_W'(M_W)));
        end
        else if (len < LEN_W'(M_W - 1))
        begin
            s = M_W'(mag << (LEN_W'(M_W - 1) - len));
        end
        else
        begin
            s = mag[M_W-1:0];
        end
        return s;
    endfunction

    logic [2:0]             neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [2:0][MAG_W-1:0]  mag1_reg, mag2_reg;
    logic [LEN_W-1:0]       len2_reg;
    logic [2:0][M_W-1:0]    m3_reg, m4_reg, m5_reg;
    logic [2:0][SQ_W-1:0]   sq4_reg;
    logic [N_W-1:0]         n5_reg;

    logic [REM_W-1:0]       sq_rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0]      sq_root_reg [SQRT_STEPS];
    logic [N_W-1:0]         sq_n_reg    [SQRT_STEPS];
    logic [2:0][M_W-1:0]    sq_m_reg    [SQRT_STEPS];
    logic [2:0]             sq_neg_reg  [SQRT_STEPS];

    logic [2:0][NUM_W-1:0]  num_reg;
    logic [ROOT_W-1:0]      r_reg;
    logic [2:0]             negp_reg;

    logic [2:0][DREM_W-1:0] dv_rem_reg [DIV_STEPS];
    logic [2:0][QT_W-1:0]   dv_q_reg   [DIV_STEPS];
    logic [2:0][NUM_W-1:0]  dv_num_reg [DIV_STEPS];
    logic [ROOT_W-1:0]      dv_r_reg   [DIV_STEPS];
    logic [2:0]             dv_neg_reg [DIV_STEPS];

    logic [2:0][U_W-1:0]    unit_reg;

    // Take magnitudes, find the common scale, scale to [2^29, 2^31), square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= vec[i][Q_W-1];
                mag1_reg[i] <= vec[i][Q_W-1] ? MAG_W'(~vec[i] + 1'b1)
                                             : vec[i][MAG_W-1:0];
                m3_reg[i]   <= scale(mag2_reg[i], len2_reg);
                sq4_reg[i]  <= m3_reg[i] * m3_reg[i];
            end
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            len2_reg <= bit_len(mag1_reg[0] | mag1_reg[1] | mag1_reg[2]);
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            m4_reg   <= m3_reg;
            neg5_reg <= neg4_reg;
            m5_reg   <= m4_reg;
            n5_reg   <= N_W'(sq4_reg[0]) + N_W'(sq4_reg[1]) + N_W'(sq4_reg[2]);
        end
    end

    // Square root, one result bit per stage
    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [N_W-1:0]      n_in;
        logic [2:0][M_W-1:0] m_in;
        logic [2:0]          neg_in;
        logic [REM_W+1:0]    rem_sh;
        logic [REM_W+1:0]    trial;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = n5_reg;
            assign m_in    = m5_reg;
            assign neg_in  = neg5_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[s-1];
            assign root_in = sq_root_reg[s-1];
            assign n_in    = sq_n_reg[s-1];
            assign m_in    = sq_m_reg[s-1];
            assign neg_in  = sq_neg_reg[s-1];
        end

        assign rem_sh = {rem_in, n_in[N_W-1-2*s -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[s]  <= REM_W'(rem_sh - trial);
                    sq_root_reg[s] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[s]  <= rem_sh[REM_W-1:0];
                    sq_root_reg[s] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                sq_n_reg[s]   <= n_in;
                sq_m_reg[s]   <= m_in;
                sq_neg_reg[s] <= neg_in;
            end
        end
    end

    // Form the rounded dividends m * 2^30 + r/2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= {sq_m_reg[SQRT_STEPS-1][i], UNIT_BITS'(0)}
                              + NUM_W'(sq_root_reg[SQRT_STEPS-1] >> 1);
            end
            r_reg    <= sq_root_reg[SQRT_STEPS-1];
            negp_reg <= sq_neg_reg[SQRT_STEPS-1];
        end
    end

    // Restoring division, one quotient bit per stage, three lanes share r
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [2:0][DREM_W-1:0] rem_in;
        logic [2:0][QT_W-1:0]   q_in;
        logic [2:0][NUM_W-1:0]  num_in;
        logic [ROOT_W-1:0]      r_in;
        logic [2:0]             neg_in;

        if (j == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = {1'b0, num_reg[i][NUM_W-1 -: QT_W]};
            end
            assign q_in   = '0;
            assign num_in = num_reg;
            assign r_in   = r_reg;
            assign neg_in = negp_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign num_in = dv_num_reg[j-1];
            assign r_in   = dv_r_reg[j-1];
            assign neg_in = dv_neg_reg[j-1];
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane_step
            logic [DREM_W:0] rem2;
            assign rem2 = {rem_in[i], num_in[i][NUM_W-QT_W-1-j]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem2 >= {1'b0, r_in})
                    begin
                        dv_rem_reg[j][i] <= DREM_W'(rem2 - {1'b0, r_in});
                        dv_q_reg[j][i]   <= {q_in[i][QT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[j][i] <= rem2[DREM_W-1:0];
                        dv_q_reg[j][i]   <= {q_in[i][QT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_num_reg[j] <= num_in;
                dv_r_reg[j]   <= r_in;
                dv_neg_reg[j] <= neg_in;
            end
        end
    end

    // Restore the component signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unit_reg[i] <= dv_neg_reg[DIV_STEPS-1][i]
                               ? ~{1'b0, dv_q_reg[DIV_STEPS-1][i]} + 1'b1
                               : {1'b0, dv_q_reg[DIV_STEPS-1][i]};
            end
        end
    end

    assign unit = unit_reg;

endmodule

// ===== src/frp_front.sv =====
module frp_front
    import frp_pkg::*;
#(
    parameter  int IN_WIDTH   = 16,
    localparam int IN_TDATA_W = ((12 * IN_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  fifo_full,
    output logic                  push,
    output frp_entry_t            entry
);

    function automatic logic [2:0][D_W-1:0] reduce3(input logic [2:0][IN_WIDTH-1:0] raw);
        logic [2:0][31:0]   mag;
        logic [31:0]        all;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   sh;
        logic signed [32:0] sx;
        logic [RED_BITS-1:0] m;
        logic [2:0][D_W-1:0] res;
        all = '0;
        for (int i = 0; i < 3; i++)
        begin
            sx     = 33'($signed(raw[i]));
            mag[i] = sx[32] ? 32'(-sx) : sx[31:0];
            all    = all | mag[i];
        end
        len = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (all[b])
            begin
                len = LEN_W'(b + 1);
            end
        end
        sh = (len > LEN_W'(RED_BITS)) ? len - LEN_W'(RED_BITS) : '0;
        for (int i = 0; i < 3; i++)
        begin
            m      = RED_BITS'(mag[i] >> sh);
            res[i] = raw[i][IN_WIDTH-1] ? ~{1'b0, m} + 1'b1 : {1'b0, m};
        end
        return res;
    endfunction

    logic [3:0]                vld_reg;
    logic                      en;
    logic [1:0][2:0][IN_WIDTH-1:0] raw_d, raw_s;
    logic [1:0][2:0][D_W-1:0]  d1_reg, s1_reg, d2_reg, d3_reg, d4_reg;
    logic [1:0][2:0][P1_W-1:0] pa2_reg, pb2_reg;
    logic [1:0][2:0][C_W-1:0]  c3_reg, c4_reg;
    logic [1:0][2:0][P2_W-1:0] qa4_reg, qb4_reg;
    logic                      dsz2_reg, dsz3_reg, deg4_reg;

    // Stall the whole front only when its last stage cannot enter the queue
    assign en            = !(vld_reg[3] && fifo_full);
    assign s_axis_tready = en;
    assign push          = vld_reg[3] && !fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], s_axis_tvalid};
        end
    end

    // Split the beat into the four vectors
    always_comb
    begin
        for (int f = 0; f < 2; f++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                raw_d[f][i] = s_axis_tdata[(6 * f + i) * IN_WIDTH +: IN_WIDTH];
                raw_s[f][i] = s_axis_tdata[(6 * f + 3 + i) * IN_WIDTH +: IN_WIDTH];
            end
        end
    end

    // Reduce, take d x s, then (d x s) x d, flagging zero or parallel inputs on the way
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int f = 0; f < 2; f++)
            begin
                d1_reg[f] <= reduce3(raw_d[f]);
                s1_reg[f] <= reduce3(raw_s[f]);

                pa2_reg[f][0] <= $signed(d1_reg[f][1]) * $signed(s1_reg[f][2]);
                pb2_reg[f][0] <= $signed(d1_reg[f][2]) * $signed(s1_reg[f][1]);
                pa2_reg[f][1] <= $signed(d1_reg[f][2]) * $signed(s1_reg[f][0]);
                pb2_reg[f][1] <= $signed(d1_reg[f][0]) * $signed(s1_reg[f][2]);
                pa2_reg[f][2] <= $signed(d1_reg[f][0]) * $signed(s1_reg[f][1]);
                pb2_reg[f][2] <= $signed(d1_reg[f][1]) * $signed(s1_reg[f][0]);

                for (int i = 0; i < 3; i++)
                begin
                    c3_reg[f][i] <= $signed(pa2_reg[f][i]) - $signed(pb2_reg[f][i]);
                end

                qa4_reg[f][0] <= $signed(c3_reg[f][1]) * $signed(d3_reg[f][2]);
                qb4_reg[f][0] <= $signed(c3_reg[f][2]) * $signed(d3_reg[f][1]);
                qa4_reg[f][1] <= $signed(c3_reg[f][2]) * $signed(d3_reg[f][0]);
                qb4_reg[f][1] <= $signed(c3_reg[f][0]) * $signed(d3_reg[f][2]);
                qa4_reg[f][2] <= $signed(c3_reg[f][0]) * $signed(d3_reg[f][1]);
                qb4_reg[f][2] <= $signed(c3_reg[f][1]) * $signed(d3_reg[f][0]);
            end
            d2_reg   <= d1_reg;
            d3_reg   <= d2_reg;
            d4_reg   <= d3_reg;
            c4_reg   <= c3_reg;
            dsz2_reg <= (d1_reg[0] == '0) || (s1_reg[0] == '0)
                        || (d1_reg[1] == '0) || (s1_reg[1] == '0);
            dsz3_reg <= dsz2_reg;
            deg4_reg <= dsz3_reg || (c3_reg[0] == '0) || (c3_reg[1] == '0);
        end
    end

    // Finish the side axis on the way into the queue
    always_comb
    begin
        entry.dir   = d4_reg;
        entry.third = c4_reg;
        entry.deg   = deg4_reg;
        for (int f = 0; f < 2; f++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                entry.side[f][i] = $signed(qa4_reg[f][i]) - $signed(qb4_reg[f][i]);
            end
        end
    end

endmodule

// ===== src/frp_fifo.sv =====
module frp_fifo
    import frp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frp_entry_t din,
    output logic       full,
    input  logic       pop,
    output frp_entry_t dout,
    output logic       empty
);

    frp_entry_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== src/frp_back.sv =====
module frp_back
    import frp_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  frp_entry_t                   din,
    input  logic                         empty,
    output logic                         pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [N_ENTRIES*OUT_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tuser
);

    localparam int LAT = NORM_LAT + 3;
    localparam int SH  = 2 * UNIT_BITS - FRAC_BITS;

    function automatic logic [OUT_W-1:0] round_entry(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rnd;
        logic [ACC_W-1:0] e;
        mag = acc[ACC_W-1] ? ~acc + 1'b1 : acc;
        rnd = (mag + (ACC_W'(1) << (SH - 1))) >> SH;
        if (rnd > (ACC_W'(1) << FRAC_BITS))
        begin
            rnd = ACC_W'(1) << FRAC_BITS;
        end
        e = acc[ACC_W-1] ? ~rnd + 1'b1 : rnd;
        return e[OUT_W-1:0];
    endfunction

    logic                          en;
    logic [LAT-1:0]                vld_reg;
    logic [LAT-1:0]                deg_reg;
    frp_vec_t                      nv [2][3];
    frp_unit_t                     nu [2][3];
    logic [2:0][2:0][2:0][PROD_W-1:0] prod_reg;
    logic [2:0][2:0][ACC_W-1:0]    acc_reg;
    logic [N_ENTRIES*OUT_W-1:0]    data_reg;

    // The back moves as one pipeline, held only by a waiting result
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign pop           = en && !empty;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tuser  = deg_reg[LAT-1];
    assign m_axis_tdata  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg <= {deg_reg[LAT-2:0], din.deg};
        end
    end

    // Widen the three exact axes of each frame for the normalizers
    always_comb
    begin
        for (int f = 0; f < 2; f++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nv[f][0][i] = Q_W'($signed(din.dir[f][i]));
                nv[f][1][i] = din.side[f][i];
                nv[f][2][i] = Q_W'($signed(din.third[f][i]));
            end
        end
    end

    for (genvar f = 0; f < 2; f++)
    begin : g_frame
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            frp_norm u_norm (
                .clk  (clk),
                .en   (en),
                .vec  (nv[f][a]),
                .unit (nu[f][a])
            );
        end
    end

    // R = A * B^T: multiply, sum over the axes, round and saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        prod_reg[i][j][k] <= $signed(nu[0][k][i]) * $signed(nu[1][k][j]);
                    end
                    acc_reg[i][j] <= $signed(prod_reg[i][j][0])
                                     + $signed(prod_reg[i][j][1])
                                     + $signed(prod_reg[i][j][2]);
                    data_reg[(i * 3 + j) * OUT_W +: OUT_W] <=
                        deg_reg[LAT-2] ? '0 : round_entry(acc_reg[i][j]);
                end
            end
        end
    end

endmodule

// ===== src/frame_pair_rotation_top.sv =====
// Channel   Dir  Beat contents (lowest bits first)
// s_axis    in   dir_a_x/y/z, side_a_x/y/z, dir_b_x/y/z, side_b_x/y/z, IN_WIDTH each
// m_axis    out  tdata: r00 r01 r02 r10 r11 r12 r20 r21 r22 (16 bits each);
//                tuser: degenerate
//
// One frame pair per cycle sustained while m_axis does not stall; a beat passes
// through the front stages, the queue and 73 back stages, set by the 32-step
// square root and 31-step divider in each normalizer.
// rst_n clears the handshake state and the four-entry queue only.
// A stalled m_axis holds the back pipeline; the front keeps accepting until
// the queue fills.
module frame_pair_rotation_top
    import frp_pkg::*;
#(
    parameter  int IN_WIDTH   = 16,
    parameter  int FRAC_BITS  = 14,
    localparam int IN_TDATA_W = ((12 * IN_WIDTH + 7) / 8) * 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // dir_a_x, dir_a_y, dir_a_z, side_a_x, side_a_y, side_a_z,
    // dir_b_x, dir_b_y, dir_b_z, side_b_x, side_b_y, side_b_z, zero pad
    input  logic [IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic [N_ENTRIES*OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic                       m_axis_tuser
);

    frp_entry_t q_in, q_out;
    logic       q_push, q_full, q_pop, q_empty;

    frp_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .fifo_full     (q_full),
        .push          (q_push),
        .entry         (q_in)
    );

    frp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    frp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (q_out),
        .empty         (q_empty),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/frame_pair_rotation_checker.sv =====
module frame_pair_rotation_checker
    import frp_pkg::*;
#(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14,
    parameter int IN_DATA_W = ((12 * IN_WIDTH + 7) / 8) * 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [N_ENTRIES*OUT_W-1:0] m_axis_tdata,
    input  logic                       m_axis_tuser,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [N_ENTRIES*OUT_W-1:0] entries;
        logic                       deg;
    } rotation_t;

    typedef longint signed vec3_t [3];
    typedef longint signed axes_t [3][3];

    rotation_t expected_rotations[$];

    function automatic longint unsigned magnitude(longint signed v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint signed with_sign(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Shift a vector down until its largest magnitude fits in 16 bits
    function automatic vec3_t shrink_vec(vec3_t v);
        longint unsigned m[3];
        longint unsigned mx;
        vec3_t r;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= 64'd65536)
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        for (int i = 0; i < 3; i++) r[i] = with_sign(m[i], v[i] < 0);
        return r;
    endfunction

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit vector in Q2.30
    function automatic vec3_t unit_vec(vec3_t v);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned n;
        longint unsigned root;
        vec3_t u;
        mx = 0;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        for (int i = 0; i < 3; i++) n += m[i] * m[i];
        root = int_sqrt(n);
        for (int i = 0; i < 3; i++)
            u[i] = with_sign(((m[i] << UNIT_BITS) + (root >> 1)) / root, v[i] < 0);
        return u;
    endfunction

    function automatic longint signed field(logic [IN_DATA_W-1:0] data, int idx);
        logic [IN_WIDTH-1:0] raw;
        raw = data[idx*IN_WIDTH +: IN_WIDTH];
        return longint'(signed'(raw));
    endfunction

    // Build the orthonormal axes of one frame; return 0 when degenerate
    function automatic bit frame_axes(logic [IN_DATA_W-1:0] data, int base,
                                      output axes_t ax);
        vec3_t d, s, c, q;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = field(data, base + i);
            s[i] = field(data, base + 3 + i);
        end
        d = shrink_vec(d);
        s = shrink_vec(s);
        ax = '{default: '{default: 0}};
        if ((d[0] == 0 && d[1] == 0 && d[2] == 0) || (s[0] == 0 && s[1] == 0 && s[2] == 0))
            return 0;
        c = cross3(d, s);
        if (c[0] == 0 && c[1] == 0 && c[2] == 0)
            return 0;
        q = cross3(c, d);
        d = unit_vec(d);
        q = unit_vec(q);
        c = unit_vec(c);
        for (int i = 0; i < 3; i++)
        begin
            ax[0][i] = d[i];
            ax[1][i] = q[i];
            ax[2][i] = c[i];
        end
        return 1;
    endfunction

    function automatic rotation_t predict_rotation(logic [IN_DATA_W-1:0] data);
        axes_t fa, fb;
        rotation_t r;
        longint signed acc;
        longint unsigned m;
        longint signed e;
        int sh;
        bit ok_a, ok_b;
        sh = 2 * UNIT_BITS - FRAC_BITS;
        ok_a = frame_axes(data, 0, fa);
        ok_b = frame_axes(data, 6, fb);
        r = '0;
        if (!ok_a || !ok_b)
        begin
            r.deg = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += fa[k][i] * fb[k][j];
                m = (magnitude(acc) + (64'd1 << (sh - 1))) >> sh;
                if (m > (64'd1 << FRAC_BITS)) m = 64'd1 << FRAC_BITS;
                e = with_sign(m, acc < 0);
                r.entries[(i*3+j)*OUT_W +: OUT_W] = e[OUT_W-1:0];
            end
        return r;
    endfunction

    assign pending = expected_rotations.size();

    // Predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        rotation_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rotations.push_back(predict_rotation(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rotations.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat: data=%h deg=%b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_rotations.pop_front();
                    if (want.entries !== m_axis_tdata || want.deg !== m_axis_tuser)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected data=%h deg=%b, got data=%h deg=%b",
                                     want.entries, want.deg, m_axis_tdata, m_axis_tuser);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_frame_pair_rotation_top.sv =====
module tb_frame_pair_rotation_top;
    import frp_pkg::*;

    localparam int IN_WIDTH   = 16;
    localparam int FRAC_BITS  = 14;
    localparam int IN_DATA_W  = ((12 * IN_WIDTH + 7) / 8) * 8;
    localparam int N_RANDOM   = 1280;
    localparam int WATCHDOG   = 4000;
    localparam int LATENCY    = 77;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_DATA_W-1:0]       s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [N_ENTRIES*OUT_W-1:0] m_axis_tdata;
    logic                       m_axis_tuser;
    int                         fail_count;
    int                         pending;
    bit                         quiet_phase;
    bit                         hold_off_req;
    int                         idle_cycles;

    frame_pair_rotation_top #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    frame_pair_rotation_checker #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    typedef logic signed [IN_WIDTH-1:0] comp_t;

    function automatic comp_t rand_comp(int mode);
        case (mode)
            0: return comp_t'($urandom);
            1: return comp_t'($urandom_range(0, 7)) - comp_t'(3);
            2: return ($urandom_range(0, 1) != 0) ? comp_t'(16'h7fff) : comp_t'(16'h8000);
            default: return comp_t'($urandom_range(0, 255)) - comp_t'(128);
        endcase
    endfunction

    // Random frame pair, sometimes with a side vector parallel to its direction or one vector zeroed
    function automatic logic [IN_DATA_W-1:0] random_pair();
        logic [IN_DATA_W-1:0] data;
        int mode;
        int pick;
        comp_t k;
        data = '0;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            data[i*IN_WIDTH +: IN_WIDTH] = rand_comp(mode < 6 ? 0 : mode - 6);
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            // side = k * dir in one frame
            k = comp_t'($urandom_range(1, 4));
            for (int i = 0; i < 3; i++)
            begin
                data[(pick*6+i)*IN_WIDTH +: IN_WIDTH] = comp_t'($urandom_range(0, 511)) - comp_t'(256);
                data[(pick*6+3+i)*IN_WIDTH +: IN_WIDTH] =
                    comp_t'(data[(pick*6+i)*IN_WIDTH +: IN_WIDTH]) * k;
            end
        end
        else if (pick == 2)
            data[$urandom_range(0, 3)*3*IN_WIDTH +: 3*IN_WIDTH] = '0;
        return data;
    endfunction

    function automatic logic [IN_DATA_W-1:0] make_pair(comp_t c [12]);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        for (int i = 0; i < 12; i++) data[i*IN_WIDTH +: IN_WIDTH] = c[i];
        return data;
    endfunction

    // Offer one beat and hold it until accepted, with random gaps before it
    task automatic send_pair(logic [IN_DATA_W-1:0] data);
        int gap;
        gap = (quiet_phase || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
            end
            stall = (quiet_phase || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("frame_pair_rotation_top verification failed");
            $finish;
        end
    end

    initial
    begin
        comp_t c [12];
        comp_t extremes [4];
        extremes = '{comp_t'(16'h8000), comp_t'(16'h7fff), comp_t'(-1), comp_t'(1)};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        quiet_phase = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity-like frames
        c = '{1, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0};
        send_pair(make_pair(c));
        c = '{0, 0, 1, 1, 0, 0, 0, 1, 0, 0, 0, -1};
        send_pair(make_pair(c));
        // Extreme components, both signs
        for (int e = 0; e < 4; e++)
        begin
            for (int i = 0; i < 12; i++) c[i] = extremes[(e + i) % 4];
            send_pair(make_pair(c));
        end
        c = '{default: comp_t'(16'h8000)};
        c[1] = comp_t'(16'h7fff);
        c[10] = comp_t'(16'h7fff);
        send_pair(make_pair(c));
        c = '{default: comp_t'(16'h7fff)};
        c[3] = comp_t'(16'h8000);
        c[9] = comp_t'(16'h8000);
        send_pair(make_pair(c));
        // Zero direction, zero side, in each frame
        c = '{0, 0, 0, 1, 2, 3, 1, 0, 0, 0, 1, 0};
        send_pair(make_pair(c));
        c = '{1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_pair(make_pair(c));
        c = '{1, 0, 0, 0, 1, 0, 0, 0, 0, 5, 5, 5};
        send_pair(make_pair(c));
        c = '{1, 0, 0, 0, 1, 0, 4, 4, 4, 0, 0, 0};
        send_pair(make_pair(c));
        // Side parallel and antiparallel to direction
        c = '{3, -5, 7, 6, -10, 14, 1, 0, 0, 0, 1, 0};
        send_pair(make_pair(c));
        c = '{1, 0, 0, 0, 1, 0, 2, 2, -2, -1, -1, 1};
        send_pair(make_pair(c));
        c = '{default: comp_t'(16'h8000)};
        send_pair(make_pair(c));
        // Nearly parallel, still valid
        c = '{1000, 0, 0, 1000, 1, 0, 0, 1000, 0, 1, 1000, 0};
        send_pair(make_pair(c));

        // Sender pauses until every result has come
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);

        // Long receiver hold-off while the sender keeps offering
        hold_off_req = 1'b1;
        for (int n = 0; n < 20; n++) send_pair(random_pair());

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 200) quiet_phase = 1'b1;
            send_pair(random_pair());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("frame_pair_rotation_top verification clean");
        else
            $display("frame_pair_rotation_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/frp_pkg.sv
src/frp_norm.sv
src/frp_front.sv
src/frp_fifo.sv
src/frp_back.sv
src/frame_pair_rotation_top.sv
tb/frame_pair_rotation_checker.sv
tb/tb_frame_pair_rotation_top.sv
